### hdl/dmtp_pkg.sv
package dmtp_pkg;

    // store geometry
    localparam int MAX_TASKS = 8;
    localparam int TIME_BITS = 16;
    localparam int SLOT_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    // interface field widths
    localparam int CMD_W      = 1;
    localparam int TSLOT_W    = 3;
    localparam int FIELD_W    = 16;
    localparam int TCOUNT_W   = 4;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 8;

    // input kinds
    localparam logic [CMD_W-1:0] CMD_LOAD = 1'b0;
    localparam logic [CMD_W-1:0] CMD_TICK = 1'b1;

    // register index
    localparam logic REG_TASK_COUNT = 1'b0;

    typedef logic [TIME_BITS-1:0] tval_t;
    typedef logic [SLOT_W-1:0]    slot_t;

    // one write into the slot store
    typedef struct packed {
        logic  we_rem;
        logic  we_cd;
        logic  we_tables;
        slot_t addr;
        tval_t rem;
        tval_t cd;
        tval_t budget;
        tval_t period;
        tval_t deadline;
    } slot_wr_t;

    // one slot as read from the store
    typedef struct packed {
        tval_t budget;
        tval_t period;
        tval_t deadline;
        tval_t rem;
        tval_t cd;
    } slot_rd_t;

    // keep a 16 bit load value in the low TIME_BITS bits
    function automatic tval_t to_tval(logic [FIELD_W-1:0] v);
        logic [FIELD_W+31:0] w;
        w = {32'b0, v};
        return w[TIME_BITS-1:0];
    endfunction

    // slot field of the stream to store index
    function automatic slot_t to_slot(logic [TSLOT_W-1:0] v);
        logic [TSLOT_W+63:0] w;
        w = {64'b0, v};
        return w[SLOT_W-1:0];
    endfunction

    // store index to the 3 bit result field
    function automatic logic [TSLOT_W-1:0] to_tslot(slot_t v);
        logic [SLOT_W+TSLOT_W-1:0] w;
        w = {{TSLOT_W{1'b0}}, v};
        return w[TSLOT_W-1:0];
    endfunction

endpackage

### hdl/deadline_monotonic_task_picker_core.sv
// deadline-monotonic tick scheduler over a small file of task slots
//
// input stream: s_tuser selects a load (0) or a tick (1). a load writes one
// slot's budget, period and deadline and restarts its work and countdown; it
// gives no result. a tick scans the active slots one per cycle through a
// shared decrement and compare unit, picks the smallest deadline with work
// left (lowest slot on ties), and updates every active countdown in the same
// pass. a final step spends a tick of the picked slot's work unless that
// slot just reloaded, and loads the output register. the active slots are
// slots 0 to min(task_count, store depth) - 1. s_tready is low until a tick
// completes, so no load or tick is taken while one is in progress.
// output stream: one transaction per tick with the served slot and idle flag.
// if the receiver stalls, the finished result holds in the output register;
// the block still takes loads and starts the next tick, and only waits at the
// final step if the previous result is still not taken.
// reset clears the sequencer and output valid and sets task_count to 1;
// slot contents are undefined until loaded. task_count is written over apb
// at addresses 0 to 3 (paddr[2] low) and should only change while the block is idle.
module deadline_monotonic_task_picker_core
    import dmtp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // task_slot, work_budget, task_period, rel_deadline
    input  logic [CMD_W-1:0]      s_tuser,   // cmd
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // served_task
    output logic                  m_tuser,   // idle
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIX
    } state_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic                found_reg;
    slot_t               pick_reg;
    tval_t               best_reg;
    tval_t               cand_rem_reg;
    logic                cand_reload_reg;
    logic [TCOUNT_W-1:0] task_count_reg;
    logic                out_valid_reg;
    logic [TSLOT_W-1:0]  served_reg;
    logic                idle_reg;

    // input field unpack
    logic [TSLOT_W-1:0] in_slot;
    logic [FIELD_W-1:0] in_budget;
    logic [FIELD_W-1:0] in_period;
    logic [FIELD_W-1:0] in_deadline;

    assign in_slot     = s_tdata[2:0];
    assign in_budget   = s_tdata[18:3];
    assign in_period   = s_tdata[34:19];
    assign in_deadline = s_tdata[50:35];

    // apb register
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TASK_COUNT);
    assign prdata = (paddr[2] == REG_TASK_COUNT) ? {28'b0, task_count_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_count_reg <= TCOUNT_W'(1);
        end
        else if (cfg_wr)
        begin
            task_count_reg <= pwdata[TCOUNT_W-1:0];
        end
    end

    // active slot count, clamped to the store depth
    logic [31:0]      tc_wide;
    logic [31:0]      act_wide;
    logic [CNT_W-1:0] active_n;
    assign tc_wide  = {28'b0, task_count_reg};
    assign act_wide = (tc_wide > MAX_TASKS) ? MAX_TASKS : tc_wide;
    assign active_n = act_wide[CNT_W-1:0];

    // handshakes
    logic in_acc;
    logic load_acc;
    logic tick_acc;
    logic out_free;
    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign load_acc = in_acc && (s_tuser == CMD_LOAD);
    assign tick_acc = in_acc && (s_tuser == CMD_TICK);
    assign out_free = !out_valid_reg || m_tready;

    // slot store and shared unit
    slot_wr_t wr;
    slot_rd_t rd;
    slot_t    scan_addr;
    tval_t    dec_a;
    tval_t    dec_y;
    logic     dec_zero;
    logic     lt;

    assign scan_addr = idx_reg[SLOT_W-1:0];

    dmtp_slot_file u_slots (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (scan_addr),
        .rd      (rd)
    );

    assign dec_a = (state_reg == S_FIX) ? cand_rem_reg : rd.cd;

    dmtp_step_unit u_step (
        .dec_a    (dec_a),
        .cmp_a    (rd.deadline),
        .cmp_b    (best_reg),
        .dec_y    (dec_y),
        .dec_zero (dec_zero),
        .lt       (lt)
    );

    // candidate test for the slot under scan
    logic take;
    assign take = (rd.rem != '0) && (!found_reg || lt);

    // store write selection
    logic       load_ok;
    logic [31:0] slot_wide;
    assign slot_wide = {29'b0, in_slot};
    assign load_ok   = load_acc && (slot_wide < MAX_TASKS);

    always_comb
    begin
        wr           = '0;
        wr.budget    = to_tval(in_budget);
        wr.period    = to_tval(in_period);
        wr.deadline  = to_tval(in_deadline);
        case (state_reg)
            S_IDLE:
            begin
                wr.addr      = to_slot(in_slot);
                wr.rem       = to_tval(in_budget);
                wr.cd        = to_tval(in_period);
                wr.we_tables = load_ok;
                wr.we_rem    = load_ok;
                wr.we_cd     = load_ok;
            end
            S_SCAN:
            begin
                // countdown step, reload on reaching zero
                wr.addr   = scan_addr;
                wr.rem    = rd.budget;
                wr.cd     = dec_zero ? rd.period : dec_y;
                wr.we_rem = dec_zero;
                wr.we_cd  = 1'b1;
            end
            S_FIX:
            begin
                // spend one tick of the granted slot unless it just reloaded
                wr.addr   = pick_reg;
                wr.rem    = dec_y;
                wr.we_rem = out_free && found_reg && !cand_reload_reg;
            end
            default:
            begin
                wr.addr = '0;
            end
        endcase
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            idx_reg         <= '0;
            found_reg       <= 1'b0;
            pick_reg        <= '0;
            best_reg        <= '0;
            cand_rem_reg    <= '0;
            cand_reload_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            served_reg      <= '0;
            idle_reg        <= 1'b0;
        end
        else
        begin
            // result taken, unless the final step reloads it this cycle
            if (out_valid_reg && m_tready && (state_reg != S_FIX))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (tick_acc)
                    begin
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        pick_reg  <= '0;
                        state_reg <= (active_n == '0) ? S_FIX : S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (take)
                    begin
                        found_reg       <= 1'b1;
                        pick_reg        <= scan_addr;
                        best_reg        <= rd.deadline;
                        cand_rem_reg    <= rd.rem;
                        cand_reload_reg <= dec_zero;
                    end
                    if (idx_reg == active_n - CNT_W'(1))
                    begin
                        state_reg <= S_FIX;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + CNT_W'(1);
                    end
                end
                S_FIX:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        served_reg    <= found_reg ? to_tslot(pick_reg) : '0;
                        idle_reg      <= !found_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-TSLOT_W){1'b0}}, served_reg};
    assign m_tuser  = idle_reg;

    // scan never runs past the active slots
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> idx_reg < active_n)
        else $error("scan index beyond active slots");

    // a granted slot is an active one
    a_pick_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIX && found_reg) |-> {1'b0, pick_reg} < {1'b0, active_n})
        else $error("granted slot not active");

    // an accepted tick starts the sequencer
    a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
        tick_acc |=> (state_reg == S_SCAN || state_reg == S_FIX))
        else $error("tick did not start a pass");

    // an idle result carries slot zero
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && idle_reg) |-> served_reg == '0)
        else $error("idle result with nonzero slot");

endmodule

### hdl/dmtp_step_unit.sv
module dmtp_step_unit
    import dmtp_pkg::*;
(
    input  tval_t dec_a,
    input  tval_t cmp_a,
    input  tval_t cmp_b,
    output tval_t dec_y,
    output logic  dec_zero,
    output logic  lt
);

    // shared decrement, wraps within TIME_BITS
    assign dec_y    = dec_a - tval_t'(1);
    assign dec_zero = (dec_y == '0);

    // shared deadline compare
    assign lt = (cmp_a < cmp_b);

endmodule

### hdl/dmtp_slot_file.sv
module dmtp_slot_file
    import dmtp_pkg::*;
(
    input  logic     clk,
    input  slot_wr_t wr,
    input  slot_t    rd_addr,
    output slot_rd_t rd
);

    tval_t budget_mem   [MAX_TASKS];
    tval_t period_mem   [MAX_TASKS];
    tval_t deadline_mem [MAX_TASKS];
    tval_t rem_mem      [MAX_TASKS];
    tval_t cd_mem       [MAX_TASKS];

    // single write port, contents undefined until loaded
    always_ff @(posedge clk)
    begin
        if (wr.we_tables)
        begin
            budget_mem[wr.addr]   <= wr.budget;
            period_mem[wr.addr]   <= wr.period;
            deadline_mem[wr.addr] <= wr.deadline;
        end
        if (wr.we_rem)
        begin
            rem_mem[wr.addr] <= wr.rem;
        end
        if (wr.we_cd)
        begin
            cd_mem[wr.addr] <= wr.cd;
        end
    end

    // single read port at the scan index
    always_comb
    begin
        rd.budget   = budget_mem[rd_addr];
        rd.period   = period_mem[rd_addr];
        rd.deadline = deadline_mem[rd_addr];
        rd.rem      = rem_mem[rd_addr];
        rd.cd       = cd_mem[rd_addr];
    end

endmodule
